// File: rtl/fpst_pkg.sv
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared types, codes and defaults for the prefix sum table unit.
// ----------------------------------------------------------------------------
package fpst_pkg;

    localparam int SIZE_DEFAULT = 1024;

    localparam int POS_W = 10;
    localparam int ADD_W = 32;
    localparam int SUM_W = 64;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_PREFIX = 2'd1;
    localparam logic [1:0] MODE_RANGE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        left_position;
        logic signed [ADD_W-1:0] add_value;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    range_error;
    } out_t;

    typedef struct packed {
        logic in_load;
        logic start_right;
        logic start_left;
        logic rd;
        logic wr_add;
        logic step_down;
        logic acc_clr;
        logic acc_en;
        logic acc_sub;
        logic clr_start;
        logic clr_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       item_bad;
        logic       node_zero;
        logic       node_over;
        logic       clr_last;
    } sts_t;

endpackage

// File: rtl/fpst_dp.sv
// ----------------------------------------------------------------------------
// fpst_dp
// Datapath: item registers, tree node walker, partial sum memory, accumulator.
// ----------------------------------------------------------------------------
module fpst_dp
    import fpst_pkg::*;
#(
    parameter int SIZE = SIZE_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  in_t  in_data,
    input  cmd_t cmd,
    output sts_t sts,
    output out_t res
);

    localparam int AW = $clog2(SIZE);
    localparam int NW = AW + 2;

    logic [1:0]       mode_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] left_reg;
    logic [SUM_W-1:0] amount_reg;
    logic [NW-1:0]    node_reg;
    logic [NW-1:0]    node_next;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] rdata_reg;
    logic [AW-1:0]    clr_reg;
    out_t             res_reg;

    logic [SUM_W-1:0] mem [SIZE];

    logic [NW-1:0] lowbit;
    logic [AW-1:0] addr;
    logic          pos_bad;
    logic          left_bad;
    logic          item_bad;

    assign lowbit   = node_reg & (~node_reg + NW'(1));
    assign addr     = AW'(node_reg - NW'(1));
    assign pos_bad  = 32'(pos_reg) >= SIZE;
    assign left_bad = 32'(left_reg) >= SIZE;
    assign item_bad = pos_bad || ((mode_reg == MODE_RANGE) && left_bad);

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_reg] <= '0;
        end else if (cmd.wr_add) begin
            mem[addr] <= rdata_reg + amount_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    always_comb begin
        node_next = node_reg;
        priority if (cmd.start_right) begin
            node_next = NW'(32'(pos_reg) + 32'd1);
        end else if (cmd.start_left) begin
            node_next = NW'(left_reg);
        end else if (cmd.wr_add) begin
            node_next = node_reg + lowbit;
        end else if (cmd.step_down) begin
            node_next = node_reg - lowbit;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        if (cmd.in_load) begin
            mode_reg   <= in_data.mode;
            pos_reg    <= in_data.position;
            left_reg   <= in_data.left_position;
            amount_reg <= {{(SUM_W-ADD_W){in_data.add_value[ADD_W-1]}}, in_data.add_value};
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= cmd.acc_sub ? acc_reg - rdata_reg : acc_reg + rdata_reg;
        end
        if (cmd.out_load) begin
            res_reg.sum         <= item_bad ? '0 : acc_reg;
            res_reg.range_error <= item_bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_start) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    assign sts.mode      = mode_reg;
    assign sts.item_bad  = item_bad;
    assign sts.node_zero = node_reg == '0;
    assign sts.node_over = 32'(node_reg) > SIZE;
    assign sts.clr_last  = clr_reg == AW'(SIZE - 1);
    assign res           = res_reg;

endmodule

// File: rtl/fpst_ctrl.sv
// ----------------------------------------------------------------------------
// fpst_ctrl
// Controller: sequences clears, tree updates, prefix walks and result transfer.
// ----------------------------------------------------------------------------
module fpst_ctrl
    import fpst_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_UPD_RD = 3'd3;
    localparam logic [2:0] ST_UPD_WR = 3'd4;
    localparam logic [2:0] ST_Q_RD   = 3'd5;
    localparam logic [2:0] ST_Q_ACC  = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       second_reg;
    logic       second_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        second_next  = second_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                second_next = 1'b0;
                unique case (sts.mode)
                    MODE_CLEAR: begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLR;
                    end
                    MODE_ADD: begin
                        cmd.start_right = 1'b1;
                        state_next      = sts.item_bad ? ST_RESULT : ST_UPD_RD;
                    end
                    default: begin
                        cmd.start_right = 1'b1;
                        cmd.acc_clr     = 1'b1;
                        state_next      = sts.item_bad ? ST_RESULT : ST_Q_RD;
                    end
                endcase
            end
            ST_UPD_RD: begin
                if (sts.node_over) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_UPD_WR;
                end
            end
            ST_UPD_WR: begin
                cmd.wr_add = 1'b1;
                state_next = ST_UPD_RD;
            end
            ST_Q_RD: begin
                if (!sts.node_zero) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_Q_ACC;
                end else if (sts.mode == MODE_RANGE && !second_reg) begin
                    cmd.start_left = 1'b1;
                    second_next    = 1'b1;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_Q_ACC: begin
                cmd.acc_en    = 1'b1;
                cmd.acc_sub   = second_reg;
                cmd.step_down = 1'b1;
                state_next    = ST_Q_RD;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/fenwick_prefix_sum_table_unit.sv
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_unit
// Binary indexed tree of 64-bit signed partial sums over SIZE positions.
//
// The s_ channel takes one command per transfer: add a value at a position,
// prefix query, range query or clear. The m_ channel returns one sum per
// query, and one error result for an update at a position beyond the table.
// Successful updates and clears return nothing.
// Each tree node costs a read state and a write or accumulate state on the
// single read/write memory port, and a range query walks two prefixes.
// A clear sweeps the memory one entry per cycle.
// After reset the same sweep runs with s_ready low.
// A finished result waits in the output register while the next command is
// taken; a later result holds in the controller until m_ready frees it.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_unit
    import fpst_pkg::*;
#(
    parameter int SIZE = SIZE_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t cmd;
    sts_t sts;

    fpst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fpst_dp #(
        .SIZE (SIZE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .res     (m_data)
    );

endmodule

// File: rtl/fpst_checker.sv
// ----------------------------------------------------------------------------
// fpst_checker
// Port-level checks for the prefix sum table unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpst_checker
    import fpst_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("command changed or dropped while waiting");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.range_error |-> m_data.sum == '0)
        else $error("error result carries a nonzero sum");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ports active after reset");

endmodule

bind fenwick_prefix_sum_table_unit fpst_checker u_fpst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: verif/fenwick_prefix_sum_table_unit_tb.sv
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_unit_tb
// Self-checking bench for the prefix sum table unit. A cycle-free model of the
// binary indexed tree predicts every returned sum from the commands that the
// unit accepts. Results are checked in order, field by field, while both
// channels stall at random. Directed edge cases run first, then a long mixed
// stream of updates, prefix and range queries and occasional clears.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_unit_tb;
    import fpst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL = SIZE_DEFAULT;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b1;
    out_t m_data;

    logic [SUM_W-1:0] tree_nodes [TBL];
    out_t pending_sums [$];
    int errors = 0;
    bit no_idle = 1'b0;
    int ready_hold = 0;

    fenwick_prefix_sum_table_unit #(.SIZE(TBL)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [SUM_W-1:0] sum_below(int unsigned count);
        logic [SUM_W-1:0] acc;
        int unsigned k;
        acc = '0;
        k = count;
        while (k > 0) begin
            acc += tree_nodes[k-1];
            k -= k & (~k + 1);
        end
        return acc;
    endfunction

    function automatic void tree_add(int unsigned pos, logic [SUM_W-1:0] amount);
        int unsigned k;
        k = pos + 1;
        while (k <= TBL) begin
            tree_nodes[k-1] += amount;
            k += k & (~k + 1);
        end
    endfunction

    function automatic void tree_clear();
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
    endfunction

    function automatic void queue_result(out_t r);
        pending_sums = {pending_sums, r};
    endfunction

    function automatic void apply_to_tree(in_t c);
        out_t r;
        int unsigned p;
        int unsigned l;
        logic [SUM_W-1:0] total;
        p = c.position;
        l = c.left_position;
        r.sum = '0;
        r.range_error = 1'b1;
        case (c.mode)
            MODE_CLEAR: begin
                tree_clear();
            end
            MODE_ADD: begin
                if (p >= TBL) queue_result(r);
                else tree_add(p, {{(SUM_W-ADD_W){c.add_value[ADD_W-1]}}, c.add_value});
            end
            default: begin
                if (p >= TBL || (c.mode == MODE_RANGE && l >= TBL)) begin
                    queue_result(r);
                end else begin
                    total = sum_below(p + 1);
                    if (c.mode == MODE_RANGE) total -= sum_below(l);
                    r.sum = total;
                    r.range_error = 1'b0;
                    queue_result(r);
                end
            end
        endcase
    endfunction

    // hold m_ready low for a random count after each transfer
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            ready_hold = no_idle ? 0 : $urandom_range(0, 4);
            m_ready <= (ready_hold == 0);
        end else if (!m_ready) begin
            if (ready_hold <= 1) m_ready <= 1'b1;
            ready_hold--;
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                $error("result transfer with nothing expected: sum %0d range_error %0b",
                       m_data.sum, m_data.range_error);
                errors++;
            end else begin
                want = pending_sums.pop_front();
                if (m_data.sum !== want.sum) begin
                    $error("sum: expected %0d, got %0d", want.sum, m_data.sum);
                    errors++;
                end
                if (m_data.range_error !== want.range_error) begin
                    $error("range_error: expected %0b, got %0b",
                           want.range_error, m_data.range_error);
                    errors++;
                end
            end
        end
    end

    task automatic send_cmd(in_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        do @(posedge aclk); while (!s_ready);
        apply_to_tree(c);
    endtask

    task automatic send_fields(logic [1:0] mode, int unsigned pos, int unsigned left,
                               logic [ADD_W-1:0] value);
        in_t c;
        c.mode = mode;
        c.position = pos[POS_W-1:0];
        c.left_position = left[POS_W-1:0];
        c.add_value = value;
        send_cmd(c);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_sums.size() != 0);
    endtask

    function automatic int unsigned pick_position();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return TBL - 1;
            2: return (1 << $urandom_range(0, POS_W - 1)) - 1;
            3: return 1 << $urandom_range(0, POS_W - 1);
            default: return $urandom_range(0, TBL - 1);
        endcase
    endfunction

    function automatic logic [ADD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t random_cmd();
        in_t c;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) c.mode = MODE_ADD;
        else if (roll < 72) c.mode = MODE_PREFIX;
        else if (roll < 98) c.mode = MODE_RANGE;
        else c.mode = MODE_CLEAR;
        c.position = POS_W'(pick_position());
        c.left_position = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                                      : POS_W'(pick_position());
        c.add_value = pick_value();
        return c;
    endfunction

    task automatic test_edge_updates();
        send_fields(MODE_PREFIX, TBL - 1, 0, 0);
        send_fields(MODE_ADD, 0, 10'h3ff, 32'h7fff_ffff);
        send_fields(MODE_ADD, TBL - 1, 0, 32'h8000_0000);
        send_fields(MODE_ADD, 512, 10'h155, 32'hffff_ffff);
        send_fields(MODE_ADD, 511, 10'h2aa, 32'h5a5a_5a5a);
        send_fields(MODE_ADD, 1, 0, 32'h0000_0000);
    endtask

    task automatic test_prefix_queries();
        send_fields(MODE_PREFIX, 0, 10'h3ff, 32'hffff_ffff);
        send_fields(MODE_PREFIX, 511, 0, 0);
        send_fields(MODE_PREFIX, 512, 0, 0);
        send_fields(MODE_PREFIX, TBL - 1, 0, 0);
    endtask

    task automatic test_range_queries();
        send_fields(MODE_RANGE, TBL - 1, 0, 0);
        send_fields(MODE_RANGE, TBL - 1, TBL - 1, 0);
        send_fields(MODE_RANGE, 512, 512, 0);
        send_fields(MODE_RANGE, 511, 512, 0);
        send_fields(MODE_RANGE, 0, TBL - 1, 0);
        send_fields(MODE_RANGE, 0, 1, 0);
        send_fields(MODE_RANGE, 700, 300, 0);
    endtask

    task automatic test_clear();
        send_fields(MODE_CLEAR, 10'h3ff, 10'h3ff, 32'hffff_ffff);
        send_fields(MODE_PREFIX, TBL - 1, 0, 0);
        send_fields(MODE_RANGE, TBL - 1, 0, 0);
        send_fields(MODE_ADD, 300, 0, 32'h0000_0007);
        send_fields(MODE_RANGE, 300, 300, 0);
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    task automatic test_paused_sender();
        test_random_traffic(40);
        drain_results();
        test_random_traffic(40);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_traffic(60);
        no_idle = 1'b0;
    endtask

    initial begin
        tree_clear();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_edge_updates();
        test_prefix_queries();
        test_range_queries();
        test_clear();
        test_random_traffic(400);
        test_paused_sender();
        test_back_to_back();
        test_random_traffic(390);
        drain_results();
        repeat (TBL + 64) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
